[rtl/gss_pkg.sv]
// Shared constants, command codes and control/status types for the golden-section search.
`timescale 1ns / 1ps

package gss_pkg;

  localparam int unsigned XW   = 32;  // Q16.16 point / value width
  localparam int unsigned LENW = 31;  // interval length width
  localparam int unsigned TOLW = 31;  // tolerance register width
  localparam int unsigned CW   = 16;  // Q0.16 constant width
  localparam int unsigned LIMW = 29;  // spacing limit width, tolerance * 0.236

  localparam logic [CW-1:0] ALPHA_Q16           = 16'd25032;
  localparam logic [CW-1:0] ONE_MINUS_ALPHA_Q16 = 16'd40504;
  localparam logic [CW-1:0] SPACING_FACTOR_Q16  = 16'd15471;

  localparam logic [TOLW-1:0] TOL_RESET = 31'd66;
  localparam logic [LIMW-1:0] LIMIT_RESET =
      LIMW'((64'(TOL_RESET) * 64'(SPACING_FACTOR_Q16)) >> 16);

  // result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_EVAL    = 2'd0;
  localparam kind_t KIND_DONE    = 2'd1;
  localparam kind_t KIND_IGNORED = 2'd2;

  // which register, or zero, goes out on a result beat
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_LOW  = 2'd0;
  localparam sel_t SEL_HIGH = 2'd1;
  localparam sel_t SEL_ZERO = 2'd2;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_VAL_LOW   = 4'd2;
  localparam op_t OP_VAL_HIGH  = 4'd3;
  localparam op_t OP_MUL_A     = 4'd4;
  localparam op_t OP_MUL_B     = 4'd5;
  localparam op_t OP_SET_LOW   = 4'd6;
  localparam op_t OP_SET_HIGH  = 4'd7;
  localparam op_t OP_SHRINK    = 4'd8;
  localparam op_t OP_GO_RIGHT  = 4'd9;
  localparam op_t OP_GO_LEFT   = 4'd10;
  localparam op_t OP_OUT       = 4'd11;

  typedef struct packed {
    op_t   op;
    kind_t kind;
    sel_t  sel;
  } cmd_t;

  typedef struct packed {
    logic stop;         // spacing within tolerance * 0.236, or length zero
    logic low_gt_high;  // f(lambda) > f(mu), signed
    logic out_free;     // output register can take a beat this cycle
  } status_t;

endpackage

[rtl/gss_datapath.sv]
// Datapath: interval registers, shared constant multiplier, saturating add, output register.
`timescale 1ns / 1ps

module gss_datapath
  import gss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic signed [XW-1:0]   start_left,
  input  logic        [LENW-1:0] start_length,
  input  logic signed [XW-1:0]   f_value,
  input  logic                   cfg_we,
  input  logic        [TOLW-1:0] cfg_wdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic        [XW-1:0]   m_axis_tdata,
  output logic        [1:0]      m_axis_tuser
);

  logic signed [XW-1:0]   left_end;
  logic        [LENW-1:0] interval_length;
  logic signed [XW-1:0]   inner_low_point;
  logic signed [XW-1:0]   inner_high_point;
  logic signed [XW-1:0]   value_at_low;
  logic signed [XW-1:0]   value_at_high;
  logic        [LENW-1:0] prod;
  logic        [LIMW-1:0] limit;

  logic        [CW-1:0]   mul_const;
  logic [LENW+CW-1:0]     mul_full;
  logic signed [XW:0]     sum;
  logic signed [XW-1:0]   sum_sat;
  logic signed [XW:0]     diff;
  logic        [XW:0]     spacing;
  logic        [XW-1:0]   out_point;

  // spacing limit is kept as tolerance * 0.236, computed at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= LIMW'((62'(cfg_wdata) * 62'(SPACING_FACTOR_Q16)) >> 16);
    end
  end

  assign mul_const = (cmd.op == OP_MUL_A) ? ALPHA_Q16 : ONE_MINUS_ALPHA_Q16;
  assign mul_full  = (LENW+CW)'(interval_length) * (LENW+CW)'(mul_const);

  assign sum = (XW+1)'(left_end) + $signed({2'b00, prod});
  always_comb begin
    if (sum[XW] != sum[XW-1]) begin
      sum_sat = sum[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    end else begin
      sum_sat = sum[XW-1:0];
    end
  end

  assign diff    = (XW+1)'(inner_low_point) - (XW+1)'(inner_high_point);
  assign spacing = diff[XW] ? (XW+1)'(-diff) : (XW+1)'(diff);

  assign status.stop        = (spacing <= (XW+1)'(limit)) || (interval_length == '0);
  assign status.low_gt_high = value_at_low > value_at_high;
  assign status.out_free    = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_end         <= '0;
      interval_length  <= '0;
      inner_low_point  <= '0;
      inner_high_point <= '0;
      value_at_low     <= '0;
      value_at_high    <= '0;
      prod             <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          left_end        <= start_left;
          interval_length <= start_length;
        end
        OP_VAL_LOW:  value_at_low  <= f_value;
        OP_VAL_HIGH: value_at_high <= f_value;
        OP_MUL_A, OP_MUL_B: prod <= mul_full[CW +: LENW];
        OP_SET_LOW:  inner_low_point  <= sum_sat;
        OP_SET_HIGH: inner_high_point <= sum_sat;
        OP_SHRINK:   interval_length  <= prod;
        OP_GO_RIGHT: begin
          left_end        <= inner_low_point;
          inner_low_point <= inner_high_point;
          value_at_low    <= value_at_high;
        end
        OP_GO_LEFT: begin
          inner_high_point <= inner_low_point;
          value_at_high    <= value_at_low;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_LOW:  out_point = inner_low_point;
      SEL_HIGH: out_point = inner_high_point;
      default:  out_point = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      m_axis_tdata <= out_point;
      m_axis_tuser <= cmd.kind;
    end
  end

endmodule

[rtl/gss_ctrl.sv]
// Controller: search phase tracking and step sequencing for the datapath.
`timescale 1ns / 1ps

module gss_ctrl
  import gss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  logic    req_type,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MUL_LOW  = 4'd1;
  localparam logic [3:0] ST_SET_LOW  = 4'd2;
  localparam logic [3:0] ST_MUL_HIGH = 4'd3;
  localparam logic [3:0] ST_SET_HIGH = 4'd4;
  localparam logic [3:0] ST_TEST     = 4'd5;
  localparam logic [3:0] ST_SHRINK   = 4'd6;
  localparam logic [3:0] ST_MOVE     = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_FIRST_LOW  = 3'd1;
  localparam logic [2:0] PH_FIRST_HIGH = 3'd2;
  localparam logic [2:0] PH_NEW_HIGH   = 3'd3;
  localparam logic [2:0] PH_NEW_LOW    = 3'd4;

  localparam logic REQ_START = 1'b0;

  logic [3:0] state, state_next;
  logic [2:0] phase, phase_next;
  logic       starting, starting_next;
  kind_t      kind, kind_next;
  sel_t       sel, sel_next;
  logic       accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    starting_next = starting;
    kind_next     = kind;
    sel_next      = sel;
    cmd.op        = OP_NONE;
    cmd.kind      = kind;
    cmd.sel       = sel;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_START) begin
            cmd.op        = OP_LOAD;
            starting_next = 1'b1;
            state_next    = ST_MUL_LOW;
          end else begin
            unique case (phase)
              PH_FIRST_LOW: begin
                cmd.op     = OP_VAL_LOW;
                kind_next  = KIND_EVAL;
                sel_next   = SEL_HIGH;
                phase_next = PH_FIRST_HIGH;
                state_next = ST_EMIT;
              end
              PH_FIRST_HIGH, PH_NEW_HIGH: begin
                cmd.op     = OP_VAL_HIGH;
                state_next = ST_TEST;
              end
              PH_NEW_LOW: begin
                cmd.op     = OP_VAL_LOW;
                state_next = ST_TEST;
              end
              default: begin
                // reply with no search running
                kind_next  = KIND_IGNORED;
                sel_next   = SEL_ZERO;
                state_next = ST_EMIT;
              end
            endcase
          end
        end
      end
      ST_MUL_LOW: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_SET_LOW;
      end
      ST_SET_LOW: begin
        cmd.op = OP_SET_LOW;
        if (starting) begin
          state_next = ST_MUL_HIGH;
        end else begin
          kind_next  = KIND_EVAL;
          sel_next   = SEL_LOW;
          phase_next = PH_NEW_LOW;
          state_next = ST_EMIT;
        end
      end
      ST_MUL_HIGH: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_SET_HIGH;
      end
      ST_SET_HIGH: begin
        cmd.op     = OP_SET_HIGH;
        kind_next  = KIND_EVAL;
        state_next = ST_EMIT;
        if (starting) begin
          starting_next = 1'b0;
          sel_next      = SEL_LOW;
          phase_next    = PH_FIRST_LOW;
        end else begin
          sel_next   = SEL_HIGH;
          phase_next = PH_NEW_HIGH;
        end
      end
      ST_TEST: begin
        if (status.stop) begin
          kind_next  = KIND_DONE;
          sel_next   = SEL_LOW;
          phase_next = PH_IDLE;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_MUL_B;
          state_next = ST_SHRINK;
        end
      end
      ST_SHRINK: begin
        cmd.op     = OP_SHRINK;
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        if (status.low_gt_high) begin
          cmd.op     = OP_GO_RIGHT;
          state_next = ST_MUL_HIGH;
        end else begin
          cmd.op     = OP_GO_LEFT;
          state_next = ST_MUL_LOW;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_IDLE;
      starting <= 1'b0;
      kind     <= KIND_EVAL;
      sel      <= SEL_ZERO;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      starting <= starting_next;
      kind     <= kind_next;
      sel      <= sel_next;
    end
  end

endmodule

[rtl/golden_section_search.sv]
// Golden-section minimum search, Q16.16, one probe or answer beat per input beat.
// From input beat to result beat: an ignored or first-value reply goes straight to
// emit, a reply that ends the search passes the test first, a start loads and then
// computes both inner points, and a reply that shrinks the interval tests, shrinks,
// moves and computes one new point (one shared 31x16 multiplier, used twice). One item
// in flight; input is taken again once its result is in the output register.
// Reset (rst, synchronous) idles the search, empties the output and sets tolerance to 66.
`timescale 1ns / 1ps

module golden_section_search
  import gss_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [TOLW-1:0] cfg_wdata,      // tolerance, unsigned Q15.16
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [95:0]     s_axis_tdata,   // start_left[31:0], start_length[62:32],
                                          // f_value[94:63], zero pad[95]
  input  logic            s_axis_tuser,   // req_type
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [XW-1:0]   m_axis_tdata,   // point_x
  output logic [1:0]      m_axis_tuser    // out_kind
);

  cmd_t    cmd;
  status_t status;

  gss_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .req_type      (s_axis_tuser),
    .status        (status),
    .cmd           (cmd)
  );

  gss_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .start_left    (s_axis_tdata[31:0]),
    .start_length  (s_axis_tdata[62:32]),
    .f_value       (s_axis_tdata[94:63]),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[tb/gss_tb_pkg.sv]
// Request codes shared by the golden-section search testbench modules.
`timescale 1ns / 1ps

package gss_tb_pkg;

  typedef enum logic {
    REQ_START = 1'b0,  // begin a new search
    REQ_VALUE = 1'b1   // function value for the last probe
  } req_e;

endpackage

[tb/golden_section_search_check.sv]
// Checker for the golden-section search: tracks the search, predicts each result beat, compares.
`timescale 1ns / 1ps

module golden_section_search_check
  import gss_pkg::*;
  import gss_tb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [TOLW-1:0] cfg_wdata,
  input  logic            s_axis_tvalid,
  input  logic            s_axis_tready,
  input  logic [95:0]     s_axis_tdata,
  input  logic            s_axis_tuser,
  input  logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  logic [XW-1:0]   m_axis_tdata,
  input  logic [1:0]      m_axis_tuser,
  output int              fail_count,
  output int              results_due
);

  localparam longint X_MAX = 64'sd2147483647;
  localparam longint X_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    SEARCH_IDLE,
    WAIT_FIRST_LOW,
    WAIT_FIRST_HIGH,
    WAIT_NEW_HIGH,
    WAIT_NEW_LOW
  } search_phase_e;

  typedef struct packed {
    kind_t         kind;
    logic [XW-1:0] x;
  } probe_t;

  logic [TOLW-1:0]      tolerance;
  logic signed [XW-1:0] left_end;
  logic signed [XW-1:0] lambda;
  logic signed [XW-1:0] mu;
  logic signed [XW-1:0] f_lambda;
  logic signed [XW-1:0] f_mu;
  logic [LENW-1:0]      span;
  search_phase_e        phase;
  probe_t               due_q[$];
  int                   errors = 0;

  // length times a Q0.16 constant, truncated
  function automatic logic [LENW-1:0] scale_by(input logic [LENW-1:0] len,
                                               input logic [CW-1:0] c);
    logic [LENW+CW-1:0] prod;
    prod = len * c;
    return prod[LENW+CW-1:CW];
  endfunction

  function automatic logic signed [XW-1:0] offset_point(input logic signed [XW-1:0] base,
                                                        input logic [LENW-1:0] delta);
    longint s;
    s = longint'(base) + longint'(delta);
    if (s > X_MAX) s = X_MAX;
    if (s < X_MIN) s = X_MIN;
    return XW'(s);
  endfunction

  task automatic report_mismatch(input string what, input logic [XW-1:0] got,
                                 input logic [XW-1:0] want);
    errors++;
    $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
  endtask

  // both values known: finish, or shrink the interval and name the next probe
  task automatic shrink_or_finish(output probe_t r);
    longint gap;
    longint limit;
    gap = longint'(lambda) - longint'(mu);
    if (gap < 0) gap = -gap;
    limit = (longint'(tolerance) * longint'(SPACING_FACTOR_Q16)) >>> 16;
    if (gap <= limit || span == '0) begin
      r = '{KIND_DONE, lambda};
      phase = SEARCH_IDLE;
    end else begin
      span = scale_by(span, ONE_MINUS_ALPHA_Q16);
      if (f_lambda > f_mu) begin
        left_end = lambda;
        lambda = mu;
        f_lambda = f_mu;
        mu = offset_point(left_end, scale_by(span, ONE_MINUS_ALPHA_Q16));
        r = '{KIND_EVAL, mu};
        phase = WAIT_NEW_HIGH;
      end else begin
        mu = lambda;
        f_mu = f_lambda;
        lambda = offset_point(left_end, scale_by(span, ALPHA_Q16));
        r = '{KIND_EVAL, lambda};
        phase = WAIT_NEW_LOW;
      end
    end
  endtask

  task automatic predict_search(input req_e req, input logic signed [XW-1:0] left,
                                input logic [LENW-1:0] len, input logic signed [XW-1:0] f,
                                output probe_t r);
    r = '{KIND_IGNORED, '0};
    if (req == REQ_START) begin
      // a start always wins, even mid-search
      left_end = left;
      span = len;
      lambda = offset_point(left, scale_by(len, ALPHA_Q16));
      mu = offset_point(left, scale_by(len, ONE_MINUS_ALPHA_Q16));
      r = '{KIND_EVAL, lambda};
      phase = WAIT_FIRST_LOW;
    end else begin
      case (phase)
        WAIT_FIRST_LOW: begin
          f_lambda = f;
          r = '{KIND_EVAL, mu};
          phase = WAIT_FIRST_HIGH;
        end
        WAIT_FIRST_HIGH, WAIT_NEW_HIGH: begin
          f_mu = f;
          shrink_or_finish(r);
        end
        WAIT_NEW_LOW: begin
          f_lambda = f;
          shrink_or_finish(r);
        end
        default: r = '{KIND_IGNORED, '0};
      endcase
    end
  endtask

  always @(posedge clk) begin
    probe_t want;
    probe_t next_r;
    if (rst) begin
      tolerance = TOL_RESET;
      left_end = '0;
      span = '0;
      lambda = '0;
      mu = '0;
      f_lambda = '0;
      f_mu = '0;
      phase = SEARCH_IDLE;
      due_q.delete();
    end else begin
      if (cfg_we) tolerance = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          report_mismatch("result beat with nothing due", m_axis_tdata, '0);
        end else begin
          want = due_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("out_kind", XW'(m_axis_tuser), XW'(want.kind));
          if (m_axis_tdata !== want.x) report_mismatch("point_x", m_axis_tdata, want.x);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_search(req_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[62:32],
                       s_axis_tdata[94:63], next_r);
        due_q.push_back(next_r);
      end
    end
    results_due <= due_q.size();
    fail_count <= errors;
  end

endmodule

[tb/golden_section_search_test.sv]
// Testbench top for the golden-section search: clock, reset, search traffic and verdict.
`timescale 1ns / 1ps

module golden_section_search_test;
  import gss_pkg::*;
  import gss_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER_BEATS = 300;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [TOLW-1:0] cfg_wdata = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [95:0]     s_axis_tdata = '0;   // start_left, start_length, f_value, pad
  logic            s_axis_tuser = 1'b0; // req_type
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [XW-1:0]   m_axis_tdata;        // point_x
  logic [1:0]      m_axis_tuser;        // out_kind

  int              fail_count;
  int              results_due;
  int              idle_cycles = 0;
  bit              quiet = 1'b0;
  bit              sender_gaps = 1'b1;
  logic [TOLW-1:0] cur_tol = TOL_RESET;

  golden_section_search u_dut (.*);
  golden_section_search_check u_check (.*);

  always #1 clk = ~clk;

  task automatic send_item(input req_e req, input logic [XW-1:0] left,
                           input logic [LENW-1:0] len, input logic [XW-1:0] f);
    if ($urandom_range(0, 63) == 0) sender_gaps = !sender_gaps;
    if (!quiet && sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {1'b0, f, len, left};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic begin_search(input logic [XW-1:0] left, input logic [LENW-1:0] len);
    send_item(REQ_START, left, len, $urandom());
  endtask

  task automatic answer_probe(input logic [XW-1:0] f);
    send_item(REQ_VALUE, $urandom(), LENW'($urandom()), f);
  endtask

  // stop offering and wait for every outstanding result beat
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_tolerance(input logic [TOLW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_tol = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [XW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 2)) - 32'd1;  // ties are likely
      default: return $urandom();
    endcase
  endfunction

  // mostly complete searches with random values; some cut short, some with stray replies
  task automatic run_searches(input int n);
    int sent;
    int est;
    int replies;
    longint rough_len;
    logic [LENW-1:0] len;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 7))
        0: len = '0;
        1: len = '1;
        2, 3: len = LENW'($urandom_range(0, 1 << 20));
        default: len = LENW'($urandom());
      endcase
      begin_search($urandom(), len);
      sent++;
      rough_len = len;
      est = 2;
      while (rough_len > cur_tol && rough_len != 0) begin
        rough_len = rough_len * 5 / 8;
        est++;
      end
      case ($urandom_range(0, 9))
        0: replies = $urandom_range(0, est);
        1: replies = est + $urandom_range(1, 3);
        default: replies = est;
      endcase
      repeat (replies) begin
        answer_probe(pick_value());
        sent++;
      end
    end
  endtask

  // result side: random stalls, one long hold, none at the end
  initial begin : result_side
    int beats;
    bit stalls_on;
    bit held;
    beats = 0;
    stalls_on = 1'b1;
    held = 1'b0;
    forever begin
      if (!quiet && !held && beats >= HOLD_AFTER_BEATS) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && stalls_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) beats++;
      if ($urandom_range(0, 63) == 0) stalls_on = !stalls_on;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_tolerance(TOL_RESET);

    // directed: idle reply, zero length, saturation, restart, ties, extreme values
    answer_probe(32'h7FFF_FFFF);
    begin_search(32'h8000_0000, '0);
    answer_probe(32'h8000_0000);
    answer_probe(32'h7FFF_FFFF);
    answer_probe(32'h0);
    begin_search(32'h7FFF_FFFF, '1);
    answer_probe(32'd5);
    answer_probe(-32'sd5);
    answer_probe(32'd7);
    answer_probe(-32'sd100);
    begin_search(32'h8000_0000, '1);
    answer_probe(32'd1);
    answer_probe(32'd1);
    answer_probe(32'h0);
    begin_search(32'h0, 31'h0001_0000);
    answer_probe(32'h8000_0000);
    answer_probe(32'h7FFF_FFFF);
    answer_probe(32'h7FFF_FFFF);
    begin_search(32'hFFFF_0000, 31'h4000_0000);
    answer_probe(32'h1234_5678);
    settle();

    set_tolerance('0);
    run_searches(350);
    settle();
    set_tolerance('1);
    run_searches(250);
    settle();
    set_tolerance(TOLW'($urandom_range(1, 1 << 16)));
    run_searches(150);
    settle();  // sender waits mid-phase for every result
    run_searches(150);
    settle();
    set_tolerance(TOLW'($urandom()));
    run_searches(250);
    settle();
    set_tolerance(TOL_RESET);
    run_searches(350);
    quiet = 1'b1;
    run_searches(150);
    settle();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gss_pkg.sv
rtl/gss_datapath.sv
rtl/gss_ctrl.sv
rtl/golden_section_search.sv
tb/gss_tb_pkg.sv
tb/golden_section_search_check.sv
tb/golden_section_search_test.sv
